FILE: rtl/lfp_pkg.sv
// Shared constants, types and arithmetic helpers for the full-pivot LU solver.
package lfp_pkg;

  localparam int MAX_SIZE   = 8;
  localparam int VALUE_BITS = 32;
  localparam int EFF_BITS   = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam int IW         = $clog2(MAX_SIZE);
  localparam int CW         = $clog2(MAX_SIZE + 1);
  localparam int AW         = 2 * IW;
  localparam int MEM_D      = MAX_SIZE * MAX_SIZE;
  localparam int PW         = 3;
  localparam int SZ_W       = 4;
  localparam int TH_W       = 17;
  localparam int DW         = 32;

  localparam logic signed [63:0] VMAX = (64'sd1 <<< (EFF_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  typedef enum logic [2:0] {
    ACT_LOAD_M = 3'd0,
    ACT_FACTOR = 3'd1,
    ACT_LOAD_R = 3'd2,
    ACT_SOLVE  = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_SOL   = 2'd1,
    KIND_INC   = 2'd2,
    KIND_ENTRY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_MATRIX_SIZE = 2'd0,
    CFG_RHS_COLUMNS = 2'd1,
    CFG_PIVOT_TH    = 2'd2,
    CFG_RESID_TH    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FSW_IN, FSW_RD, FSW_TMP, FSW_DIV, FSW_SUB
  } fs_wsel_e;

  typedef enum logic {YSW_ACC, YSW_DIV} ys_wsel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_FS, ACC_RS, ACC_YS, ACC_SUB
  } acc_sel_e;

  typedef enum logic [1:0] {MUL_NONE, MUL_LM, MUL_YS} mul_sel_e;

  typedef enum logic [1:0] {OV_ZERO, OV_FS, OV_YS} out_vsel_e;

  typedef enum logic {DIV_FS, DIV_ACC} div_src_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic [AW-1:0] fs_raddr;
    logic [AW-1:0] fs_waddr;
    logic          fs_we;
    fs_wsel_e      fs_wsel;
    logic [AW-1:0] rs_raddr;
    logic [AW-1:0] rs_waddr;
    logic          rs_we;
    logic [AW-1:0] ys_raddr;
    logic [AW-1:0] ys_waddr;
    logic          ys_we;
    ys_wsel_e      ys_wsel;
    logic          tmp_ld;
    logic          piv_ld;
    logic          best_init;
    logic          best_cmp;
    logic          lm_ld;
    logic          scale_en;
    logic          div_start;
    div_src_e      div_src;
    acc_sel_e      acc_sel;
    mul_sel_e      mul_sel;
    logic          out_ld;
    kind_e         out_kind;
    logic [CW-1:0] out_rank;
    logic [IW-1:0] out_row;
    logic [IW-1:0] out_col;
    out_vsel_e     out_vsel;
    logic [IW-1:0] out_rsrc;
    logic [IW-1:0] out_csrc;
    logic          out_last;
  } lfp_cmd_t;

  // Status from the datapath back to the sequencer
  typedef struct packed {
    logic gt;
    logic piv_small;
    logic y_big;
    logic div_done;
  } lfp_stat_t;

  function automatic logic signed [DW-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > VMAX) r = VMAX;
    if (v < VMIN) r = VMIN;
    return r[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [CW-1:0] clamp_cnt(input logic [SZ_W-1:0] v);
    logic [CW-1:0] r;
    r = CW'(v);
    if (v == '0) r = CW'(1);
    if (32'(v) > MAX_SIZE) r = CW'(MAX_SIZE);
    return r;
  endfunction

  function automatic logic [AW-1:0] ent_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return {r[IW-1:0], c[IW-1:0]};
  endfunction

endpackage

FILE: rtl/lfp_div.sv
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturating.
module lfp_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [31:0]    num_i,
  input  logic signed [31:0]    den_i,
  output logic                  done_o,
  output logic signed [31:0]    q_o
);

  logic        busy_q, fin_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [47:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] dmag_q;
  logic signed [31:0] q_q;
  logic [32:0] rem_sh;
  logic        fits;

  // Shift in one dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh = {rem_q[31:0], quo_q[47]};
    fits   = rem_sh >= {1'b0, dmag_q};
  end

  // Control: start, iterate, finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Data: remainder, quotient shift register, result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dmag_q <= lfp_pkg::mag(den_i);
      quo_q  <= {lfp_pkg::mag(num_i), 16'b0};
      rem_q  <= '0;
      neg_q  <= num_i[31] ^ den_i[31];
      if (den_i == '0) begin
        if (num_i > 0) q_q <= lfp_pkg::VMAX[31:0];
        else if (num_i < 0) q_q <= lfp_pkg::VMIN[31:0];
        else q_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
      quo_q <= {quo_q[46:0], fits};
    end else if (fin_q) begin
      q_q <= lfp_pkg::sat(neg_q ? -$signed({16'b0, quo_q}) : $signed({16'b0, quo_q}));
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

FILE: rtl/lfp_dp.sv
// Datapath: factor, rhs and work memories, multiply/scale/subtract, divider, result register.
module lfp_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lfp_pkg::lfp_cmd_t           cmd_i,
  output lfp_pkg::lfp_stat_t          stat_o,
  input  logic signed [31:0]          value_i,
  input  logic [lfp_pkg::TH_W-1:0]    pivot_th_i,
  input  logic [lfp_pkg::TH_W-1:0]    resid_th_i,
  output logic [1:0]                  kind_o,
  output logic [lfp_pkg::CW-1:0]      rank_o,
  output logic [lfp_pkg::PW-1:0]      row_res_o,
  output logic [lfp_pkg::PW-1:0]      col_res_o,
  output logic signed [31:0]          value_res_o,
  output logic [lfp_pkg::PW-1:0]      row_source_o,
  output logic [lfp_pkg::PW-1:0]      col_source_o,
  output logic                        last_o
);

  logic signed [31:0] fs_mem [lfp_pkg::MEM_D];
  logic signed [31:0] rs_mem [lfp_pkg::MEM_D];
  logic signed [31:0] ys_mem [lfp_pkg::MEM_D];
  logic signed [31:0] fs_rd_q, rs_rd_q, ys_rd_q;
  logic signed [31:0] fs_wdata, ys_wdata, in_val;
  logic signed [31:0] tmp_q, piv_q, lm_q, acc_q, scl_q, sub_res, mul_b, div_num, div_q;
  logic signed [63:0] prod_q, adj;
  logic [31:0]        best_q, fs_mag;
  logic               div_done;

  logic [1:0]                kind_q;
  logic [lfp_pkg::CW-1:0]    rank_q;
  logic [lfp_pkg::PW-1:0]    row_q, col_q, rsrc_q, csrc_q;
  logic signed [31:0]        val_q;
  logic                      last_q;

  // Arithmetic helpers
  always_comb begin
    in_val  = lfp_pkg::sat(64'(value_i));
    sub_res = lfp_pkg::sat(64'(acc_q) - 64'(scl_q));
    fs_mag  = lfp_pkg::mag(fs_rd_q);
    adj     = prod_q[63] ? (prod_q + 64'sd65535) : prod_q;
    mul_b   = (cmd_i.mul_sel == lfp_pkg::MUL_LM) ? lm_q : ys_rd_q;
    div_num = (cmd_i.div_src == lfp_pkg::DIV_FS) ? fs_rd_q : acc_q;
  end

  // Select memory write data
  always_comb begin
    case (cmd_i.fs_wsel)
      lfp_pkg::FSW_IN:  fs_wdata = in_val;
      lfp_pkg::FSW_RD:  fs_wdata = fs_rd_q;
      lfp_pkg::FSW_TMP: fs_wdata = tmp_q;
      lfp_pkg::FSW_DIV: fs_wdata = div_q;
      default:          fs_wdata = sub_res;
    endcase
    ys_wdata = (cmd_i.ys_wsel == lfp_pkg::YSW_ACC) ? acc_q : div_q;
  end

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (cmd_i.fs_we) fs_mem[cmd_i.fs_waddr] <= fs_wdata;
    fs_rd_q <= fs_mem[cmd_i.fs_raddr];
    if (cmd_i.rs_we) rs_mem[cmd_i.rs_waddr] <= in_val;
    rs_rd_q <= rs_mem[cmd_i.rs_raddr];
    if (cmd_i.ys_we) ys_mem[cmd_i.ys_waddr] <= ys_wdata;
    ys_rd_q <= ys_mem[cmd_i.ys_raddr];
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tmp_ld) tmp_q <= fs_rd_q;
    if (cmd_i.piv_ld) piv_q <= fs_rd_q;
    if (cmd_i.best_init || (cmd_i.best_cmp && stat_o.gt)) best_q <= fs_mag;
    if (cmd_i.lm_ld) lm_q <= div_q;
    if (cmd_i.mul_sel != lfp_pkg::MUL_NONE) prod_q <= fs_rd_q * mul_b;
    if (cmd_i.scale_en) scl_q <= lfp_pkg::sat(adj >>> 16);
    case (cmd_i.acc_sel)
      lfp_pkg::ACC_FS:  acc_q <= fs_rd_q;
      lfp_pkg::ACC_RS:  acc_q <= rs_rd_q;
      lfp_pkg::ACC_YS:  acc_q <= ys_rd_q;
      lfp_pkg::ACC_SUB: acc_q <= sub_res;
      default:          acc_q <= acc_q;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      kind_q <= cmd_i.out_kind;
      rank_q <= cmd_i.out_rank;
      row_q  <= lfp_pkg::PW'(cmd_i.out_row);
      col_q  <= lfp_pkg::PW'(cmd_i.out_col);
      rsrc_q <= lfp_pkg::PW'(cmd_i.out_rsrc);
      csrc_q <= lfp_pkg::PW'(cmd_i.out_csrc);
      last_q <= cmd_i.out_last;
      case (cmd_i.out_vsel)
        lfp_pkg::OV_FS: val_q <= fs_rd_q;
        lfp_pkg::OV_YS: val_q <= ys_rd_q;
        default:        val_q <= '0;
      endcase
    end
  end

  lfp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (piv_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Status back to the sequencer
  always_comb begin
    stat_o.gt        = fs_mag > best_q;
    stat_o.piv_small = lfp_pkg::mag(piv_q) < 32'(pivot_th_i);
    stat_o.y_big     = lfp_pkg::mag(ys_rd_q) > 32'(resid_th_i);
    stat_o.div_done  = div_done;
  end

  assign kind_o       = kind_q;
  assign rank_o       = rank_q;
  assign row_res_o    = row_q;
  assign col_res_o    = col_q;
  assign value_res_o  = val_q;
  assign row_source_o = rsrc_q;
  assign col_source_o = csrc_q;
  assign last_o       = last_q;

endmodule

FILE: rtl/lfp_ctrl.sv
// Sequencer: request handshake, loop counters, permutations and datapath commands.
module lfp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 action_i,
  input  logic [lfp_pkg::PW-1:0]     row_i,
  input  logic [lfp_pkg::PW-1:0]     col_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic [lfp_pkg::SZ_W-1:0]   matrix_size_i,
  input  logic [lfp_pkg::SZ_W-1:0]   rhs_columns_i,
  input  lfp_pkg::lfp_stat_t         stat_i,
  output lfp_pkg::lfp_cmd_t          cmd_o
);

  localparam int CW = lfp_pkg::CW;
  localparam int IW = lfp_pkg::IW;

  typedef enum logic [5:0] {
    ST_IDLE, ST_RD_A, ST_RD_O,
    ST_F_START, ST_F_SR, ST_F_SC, ST_F_SWO,
    ST_F_RR1, ST_F_RR2, ST_F_RW1, ST_F_RW2,
    ST_F_CR1, ST_F_CR2, ST_F_CW1, ST_F_CW2,
    ST_F_PR, ST_F_PL, ST_F_PC,
    ST_F_EJ, ST_F_ED, ST_F_EDW, ST_F_EK, ST_F_EM, ST_F_EA, ST_F_EW, ST_F_DONE,
    ST_S_FI, ST_S_FJ, ST_S_FA, ST_S_FK, ST_S_FM, ST_S_FS, ST_S_FU,
    ST_S_CI, ST_S_CL, ST_S_CP, ST_S_CJ, ST_S_CY, ST_S_INC,
    ST_S_BI, ST_S_BC, ST_S_BP, ST_S_BJ, ST_S_BA, ST_S_BK, ST_S_BM, ST_S_BS,
    ST_S_BU, ST_S_BD, ST_S_BDW,
    ST_S_EI, ST_S_EJ, ST_S_EO
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       i_q, i_d, j_q, j_d, k_q, k_d, rank_q, rank_d;
  logic [IW-1:0]       br_q, br_d, bc_q, bc_d;
  logic [IW-1:0]       rord_q [lfp_pkg::MAX_SIZE];
  logic [IW-1:0]       rord_d [lfp_pkg::MAX_SIZE];
  logic [IW-1:0]       cord_q [lfp_pkg::MAX_SIZE];
  logic [IW-1:0]       cord_d [lfp_pkg::MAX_SIZE];
  logic [lfp_pkg::PW-1:0] r_q, r_d, c_q, c_d;
  logic                out_valid_q, out_valid_d;
  logic [CW-1:0]       n, m, i1, j1, k1;
  logic [IW-1:0]       ii;
  logic                accept, ok_in, ok_q;

  assign n      = lfp_pkg::clamp_cnt(matrix_size_i);
  assign m      = lfp_pkg::clamp_cnt(rhs_columns_i);
  assign i1     = i_q + CW'(1);
  assign j1     = j_q + CW'(1);
  assign k1     = k_q + CW'(1);
  assign ii     = i_q[IW-1:0];
  assign ok_in  = (32'(row_i) < lfp_pkg::MAX_SIZE) && (32'(col_i) < lfp_pkg::MAX_SIZE);
  assign ok_q   = (32'(r_q) < lfp_pkg::MAX_SIZE) && (32'(c_q) < lfp_pkg::MAX_SIZE);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    rank_d      = rank_q;
    br_d        = br_q;
    bc_d        = bc_q;
    rord_d      = rord_q;
    cord_d      = cord_q;
    r_d         = r_q;
    c_d         = c_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.out_rank = rank_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (lfp_pkg::action_e'(action_i))
            lfp_pkg::ACT_LOAD_M: begin
              cmd_o.fs_we    = ok_in;
              cmd_o.fs_waddr = lfp_pkg::ent_addr(CW'(row_i), CW'(col_i));
              cmd_o.fs_wsel  = lfp_pkg::FSW_IN;
            end
            lfp_pkg::ACT_LOAD_R: begin
              cmd_o.rs_we    = ok_in;
              cmd_o.rs_waddr = lfp_pkg::ent_addr(CW'(row_i), CW'(col_i));
            end
            lfp_pkg::ACT_FACTOR: begin
              for (int x = 0; x < lfp_pkg::MAX_SIZE; x++) begin
                rord_d[x] = IW'(x);
                cord_d[x] = IW'(x);
              end
              rank_d  = '0;
              i_d     = '0;
              state_d = ST_F_START;
            end
            lfp_pkg::ACT_SOLVE: begin
              i_d     = '0;
              state_d = ST_S_FI;
            end
            lfp_pkg::ACT_READ: begin
              r_d     = row_i;
              c_d     = col_i;
              state_d = ST_RD_A;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // Read one packed entry
      ST_RD_A: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(CW'(r_q), CW'(c_q));
        if (!out_valid_q) state_d = ST_RD_O;
      end
      ST_RD_O: begin
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_kind = lfp_pkg::KIND_ENTRY;
        cmd_o.out_row  = IW'(r_q);
        cmd_o.out_col  = IW'(c_q);
        cmd_o.out_vsel = ok_q ? lfp_pkg::OV_FS : lfp_pkg::OV_ZERO;
        cmd_o.out_rsrc = ok_q ? rord_q[IW'(r_q)] : '0;
        cmd_o.out_csrc = ok_q ? cord_q[IW'(c_q)] : '0;
        cmd_o.out_last = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = ST_IDLE;
      end

      // Pivot search over the remaining submatrix
      ST_F_START: begin
        if (i_q == n) begin
          state_d = ST_F_DONE;
        end else begin
          j_d     = i_q;
          k_d     = i_q;
          br_d    = ii;
          bc_d    = ii;
          state_d = ST_F_SR;
        end
      end
      ST_F_SR: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(j_q, k_q);
        state_d        = ST_F_SC;
      end
      ST_F_SC: begin
        if ((j_q == i_q) && (k_q == i_q)) begin
          cmd_o.best_init = 1'b1;
        end else begin
          cmd_o.best_cmp = 1'b1;
          if (stat_i.gt) begin
            br_d = j_q[IW-1:0];
            bc_d = k_q[IW-1:0];
          end
        end
        state_d = ST_F_SR;
        if (k1 == n) begin
          k_d = i_q;
          if (j1 == n) state_d = ST_F_SWO;
          else j_d = j1;
        end else begin
          k_d = k1;
        end
      end
      ST_F_SWO: begin
        rord_d[ii]   = rord_q[br_q];
        rord_d[br_q] = rord_q[ii];
        cord_d[ii]   = cord_q[bc_q];
        cord_d[bc_q] = cord_q[ii];
        k_d          = '0;
        state_d      = ST_F_RR1;
      end

      // Swap rows i and br
      ST_F_RR1: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(i_q, k_q);
        state_d        = ST_F_RR2;
      end
      ST_F_RR2: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(CW'(br_q), k_q);
        cmd_o.tmp_ld   = 1'b1;
        state_d        = ST_F_RW1;
      end
      ST_F_RW1: begin
        cmd_o.fs_we    = 1'b1;
        cmd_o.fs_waddr = lfp_pkg::ent_addr(i_q, k_q);
        cmd_o.fs_wsel  = lfp_pkg::FSW_RD;
        state_d        = ST_F_RW2;
      end
      ST_F_RW2: begin
        cmd_o.fs_we    = 1'b1;
        cmd_o.fs_waddr = lfp_pkg::ent_addr(CW'(br_q), k_q);
        cmd_o.fs_wsel  = lfp_pkg::FSW_TMP;
        if (k1 == n) begin
          j_d     = '0;
          state_d = ST_F_CR1;
        end else begin
          k_d     = k1;
          state_d = ST_F_RR1;
        end
      end

      // Swap columns i and bc
      ST_F_CR1: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(j_q, i_q);
        state_d        = ST_F_CR2;
      end
      ST_F_CR2: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(j_q, CW'(bc_q));
        cmd_o.tmp_ld   = 1'b1;
        state_d        = ST_F_CW1;
      end
      ST_F_CW1: begin
        cmd_o.fs_we    = 1'b1;
        cmd_o.fs_waddr = lfp_pkg::ent_addr(j_q, i_q);
        cmd_o.fs_wsel  = lfp_pkg::FSW_RD;
        state_d        = ST_F_CW2;
      end
      ST_F_CW2: begin
        cmd_o.fs_we    = 1'b1;
        cmd_o.fs_waddr = lfp_pkg::ent_addr(j_q, CW'(bc_q));
        cmd_o.fs_wsel  = lfp_pkg::FSW_TMP;
        if (j1 == n) begin
          state_d = ST_F_PR;
        end else begin
          j_d     = j1;
          state_d = ST_F_CR1;
        end
      end

      // Check the pivot
      ST_F_PR: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(i_q, i_q);
        state_d        = ST_F_PL;
      end
      ST_F_PL: begin
        cmd_o.piv_ld = 1'b1;
        state_d      = ST_F_PC;
      end
      ST_F_PC: begin
        if (stat_i.piv_small) begin
          rank_d  = i_q;
          state_d = ST_F_DONE;
        end else begin
          rank_d  = i1;
          j_d     = i1;
          state_d = ST_F_EJ;
        end
      end

      // Eliminate below the pivot
      ST_F_EJ: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(j_q, i_q);
        if (j_q == n) begin
          i_d     = i1;
          state_d = ST_F_START;
        end else begin
          state_d = ST_F_ED;
        end
      end
      ST_F_ED: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = lfp_pkg::DIV_FS;
        state_d         = ST_F_EDW;
      end
      ST_F_EDW: begin
        if (stat_i.div_done) begin
          cmd_o.lm_ld    = 1'b1;
          cmd_o.fs_we    = 1'b1;
          cmd_o.fs_waddr = lfp_pkg::ent_addr(j_q, i_q);
          cmd_o.fs_wsel  = lfp_pkg::FSW_DIV;
          k_d            = i1;
          state_d        = ST_F_EK;
        end
      end
      ST_F_EK: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(i_q, k_q);
        if (k_q == n) begin
          j_d     = j1;
          state_d = ST_F_EJ;
        end else begin
          state_d = ST_F_EM;
        end
      end
      ST_F_EM: begin
        cmd_o.mul_sel  = lfp_pkg::MUL_LM;
        cmd_o.fs_raddr = lfp_pkg::ent_addr(j_q, k_q);
        state_d        = ST_F_EA;
      end
      ST_F_EA: begin
        cmd_o.acc_sel  = lfp_pkg::ACC_FS;
        cmd_o.scale_en = 1'b1;
        state_d        = ST_F_EW;
      end
      ST_F_EW: begin
        cmd_o.fs_we    = 1'b1;
        cmd_o.fs_waddr = lfp_pkg::ent_addr(j_q, k_q);
        cmd_o.fs_wsel  = lfp_pkg::FSW_SUB;
        k_d            = k1;
        state_d        = ST_F_EK;
      end
      ST_F_DONE: begin
        if (!out_valid_q) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_kind = lfp_pkg::KIND_DONE;
          cmd_o.out_rank = rank_q;
          cmd_o.out_vsel = lfp_pkg::OV_ZERO;
          cmd_o.out_last = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      // Forward substitution on row-permuted right-hand sides
      ST_S_FI: begin
        j_d = '0;
        if (i_q == n) begin
          i_d     = '0;
          state_d = ST_S_CI;
        end else begin
          state_d = ST_S_FJ;
        end
      end
      ST_S_FJ: begin
        cmd_o.rs_raddr = lfp_pkg::ent_addr(CW'(rord_q[ii]), j_q);
        k_d            = '0;
        if (j_q == m) begin
          i_d     = i1;
          state_d = ST_S_FI;
        end else begin
          state_d = ST_S_FA;
        end
      end
      ST_S_FA: begin
        cmd_o.acc_sel = lfp_pkg::ACC_RS;
        state_d       = ST_S_FK;
      end
      ST_S_FK: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(i_q, k_q);
        cmd_o.ys_raddr = lfp_pkg::ent_addr(k_q, j_q);
        if (k_q == i_q) begin
          cmd_o.ys_we    = 1'b1;
          cmd_o.ys_waddr = lfp_pkg::ent_addr(i_q, j_q);
          cmd_o.ys_wsel  = lfp_pkg::YSW_ACC;
          j_d            = j1;
          state_d        = ST_S_FJ;
        end else begin
          state_d = ST_S_FM;
        end
      end
      ST_S_FM: begin
        cmd_o.mul_sel = lfp_pkg::MUL_YS;
        state_d       = ST_S_FS;
      end
      ST_S_FS: begin
        cmd_o.scale_en = 1'b1;
        state_d        = ST_S_FU;
      end
      ST_S_FU: begin
        cmd_o.acc_sel = lfp_pkg::ACC_SUB;
        k_d           = k1;
        state_d       = ST_S_FK;
      end

      // Compatibility check on rows with a tiny diagonal
      ST_S_CI: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(i_q, i_q);
        if (i_q == n) state_d = ST_S_BI;
        else state_d = ST_S_CL;
      end
      ST_S_CL: begin
        cmd_o.piv_ld = 1'b1;
        state_d      = ST_S_CP;
      end
      ST_S_CP: begin
        j_d = '0;
        if (stat_i.piv_small) begin
          state_d = ST_S_CJ;
        end else begin
          i_d     = i1;
          state_d = ST_S_CI;
        end
      end
      ST_S_CJ: begin
        cmd_o.ys_raddr = lfp_pkg::ent_addr(i_q, j_q);
        if (j_q == m) begin
          i_d     = i1;
          state_d = ST_S_CI;
        end else begin
          state_d = ST_S_CY;
        end
      end
      ST_S_CY: begin
        if (stat_i.y_big) begin
          state_d = ST_S_INC;
        end else begin
          j_d     = j1;
          state_d = ST_S_CJ;
        end
      end
      ST_S_INC: begin
        if (!out_valid_q) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_kind = lfp_pkg::KIND_INC;
          cmd_o.out_vsel = lfp_pkg::OV_ZERO;
          cmd_o.out_last = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      // Back substitution, last row first, up to the rank
      ST_S_BI: begin
        if (i_q == '0) begin
          state_d = ST_S_EI;
        end else begin
          i_d     = i_q - CW'(1);
          state_d = ST_S_BC;
        end
      end
      ST_S_BC: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(i_q, i_q);
        if (i_q >= rank_q) state_d = ST_S_BI;
        else state_d = ST_S_BP;
      end
      ST_S_BP: begin
        cmd_o.piv_ld = 1'b1;
        j_d          = '0;
        state_d      = ST_S_BJ;
      end
      ST_S_BJ: begin
        cmd_o.ys_raddr = lfp_pkg::ent_addr(i_q, j_q);
        if (j_q == m) state_d = ST_S_BI;
        else state_d = ST_S_BA;
      end
      ST_S_BA: begin
        cmd_o.acc_sel = lfp_pkg::ACC_YS;
        k_d           = i1;
        state_d       = ST_S_BK;
      end
      ST_S_BK: begin
        cmd_o.fs_raddr = lfp_pkg::ent_addr(i_q, k_q);
        cmd_o.ys_raddr = lfp_pkg::ent_addr(k_q, j_q);
        if (k_q == n) state_d = ST_S_BD;
        else state_d = ST_S_BM;
      end
      ST_S_BM: begin
        cmd_o.mul_sel = lfp_pkg::MUL_YS;
        state_d       = ST_S_BS;
      end
      ST_S_BS: begin
        cmd_o.scale_en = 1'b1;
        state_d        = ST_S_BU;
      end
      ST_S_BU: begin
        cmd_o.acc_sel = lfp_pkg::ACC_SUB;
        k_d           = k1;
        state_d       = ST_S_BK;
      end
      ST_S_BD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = lfp_pkg::DIV_ACC;
        state_d         = ST_S_BDW;
      end
      ST_S_BDW: begin
        if (stat_i.div_done) begin
          cmd_o.ys_we    = 1'b1;
          cmd_o.ys_waddr = lfp_pkg::ent_addr(i_q, j_q);
          cmd_o.ys_wsel  = lfp_pkg::YSW_DIV;
          j_d            = j1;
          state_d        = ST_S_BJ;
        end
      end

      // Emit solution entries in pivot order
      ST_S_EI: begin
        j_d = '0;
        if (i_q == n) state_d = ST_IDLE;
        else state_d = ST_S_EJ;
      end
      ST_S_EJ: begin
        cmd_o.ys_raddr = lfp_pkg::ent_addr(i_q, j_q);
        if (j_q == m) begin
          i_d     = i1;
          state_d = ST_S_EI;
        end else if (!out_valid_q) begin
          state_d = ST_S_EO;
        end
      end
      ST_S_EO: begin
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_kind = lfp_pkg::KIND_SOL;
        cmd_o.out_row  = cord_q[ii];
        cmd_o.out_col  = j_q[IW-1:0];
        cmd_o.out_vsel = lfp_pkg::OV_YS;
        cmd_o.out_last = (i1 == n) && (j1 == m);
        out_valid_d    = 1'b1;
        j_d            = j1;
        state_d        = ST_S_EJ;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, counters, permutations and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rank_q      <= '0;
      br_q        <= '0;
      bc_q        <= '0;
      r_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
      for (int x = 0; x < lfp_pkg::MAX_SIZE; x++) begin
        rord_q[x] <= IW'(x);
        cord_q[x] <= IW'(x);
      end
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      rank_q      <= rank_d;
      br_q        <= br_d;
      bc_q        <= bc_d;
      r_q         <= r_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
      rord_q      <= rord_d;
      cord_q      <= cord_d;
    end
  end

endmodule

FILE: rtl/lu_full_pivot_solver.sv
// Loads are written as their request is accepted; a read passes through ST_RD_A and
// ST_RD_O, waiting while an earlier result is not yet taken, then registers its entry.
// Factoring searches the remaining submatrix, swaps rows and columns element by element,
// divides each multiplier on the bit-serial divider and updates; solve uses that divider too.
// One request is worked at a time; the pace is set by the single memory read port per store.
// Reset clears the sequencer, the permutations (identity), the rank and the loop counters.
module lu_full_pivot_solver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  action_i,
  input  logic [lfp_pkg::PW-1:0]      row_i,
  input  logic [lfp_pkg::PW-1:0]      col_i,
  input  logic signed [31:0]          value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [lfp_pkg::CW-1:0]      rank_o,
  output logic [lfp_pkg::PW-1:0]      row_res_o,
  output logic [lfp_pkg::PW-1:0]      col_res_o,
  output logic signed [31:0]          value_res_o,
  output logic [lfp_pkg::PW-1:0]      row_source_o,
  output logic [lfp_pkg::PW-1:0]      col_source_o,
  output logic                        last_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [lfp_pkg::TH_W-1:0]    cfg_data_i
);

  logic [lfp_pkg::SZ_W-1:0] matrix_size_q, rhs_columns_q;
  logic [lfp_pkg::TH_W-1:0] pivot_th_q, resid_th_q;
  lfp_pkg::lfp_cmd_t        cmd;
  lfp_pkg::lfp_stat_t       stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= lfp_pkg::SZ_W'(8);
      rhs_columns_q <= lfp_pkg::SZ_W'(1);
      pivot_th_q    <= lfp_pkg::TH_W'(1);
      resid_th_q    <= lfp_pkg::TH_W'(1);
    end else if (cfg_we_i) begin
      unique case (lfp_pkg::cfg_idx_e'(cfg_index_i))
        lfp_pkg::CFG_MATRIX_SIZE: matrix_size_q <= cfg_data_i[lfp_pkg::SZ_W-1:0];
        lfp_pkg::CFG_RHS_COLUMNS: rhs_columns_q <= cfg_data_i[lfp_pkg::SZ_W-1:0];
        lfp_pkg::CFG_PIVOT_TH:    pivot_th_q    <= cfg_data_i;
        lfp_pkg::CFG_RESID_TH:    resid_th_q    <= cfg_data_i;
        default:                  pivot_th_q    <= pivot_th_q;
      endcase
    end
  end

  lfp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .matrix_size_i (matrix_size_q),
    .rhs_columns_i (rhs_columns_q),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  lfp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (value_i),
    .pivot_th_i   (pivot_th_q),
    .resid_th_i   (resid_th_q),
    .kind_o       (kind_o),
    .rank_o       (rank_o),
    .row_res_o    (row_res_o),
    .col_res_o    (col_res_o),
    .value_res_o  (value_res_o),
    .row_source_o (row_source_o),
    .col_source_o (col_source_o),
    .last_o       (last_o)
  );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the full-pivot LU solver: random matrices and right-hand sides.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int SETTLE       = 60;

  typedef struct {
    logic [2:0]         action;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } req_t;

  typedef struct {
    lfp_pkg::kind_e     kind;
    logic [3:0]         rank;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic [2:0]         rsrc;
    logic [2:0]         csrc;
    logic               last;
  } answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         action_i = '0;
  logic [2:0]         row_i = '0;
  logic [2:0]         col_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [3:0]         rank_o;
  logic [2:0]         row_res_o;
  logic [2:0]         col_res_o;
  logic signed [31:0] value_res_o;
  logic [2:0]         row_source_o;
  logic [2:0]         col_source_o;
  logic               last_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [16:0]        cfg_data_i = '0;

  lu_full_pivot_solver u_dut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the solver state
  logic signed [31:0] lu_mat [8][8];
  logic signed [31:0] rhs_mat [8][8];
  logic [2:0]         row_perm [8];
  logic [2:0]         col_perm [8];
  logic [3:0]         shadow_rank;
  logic [3:0]         size_reg;
  logic [3:0]         cols_reg;
  longint             piv_th;
  longint             res_th;

  req_t    pending_q [$];
  answer_t answer_q [$];

  // Generator-side bookkeeping of what has been loaded
  bit  mat_loaded [8][8];
  bit  rhs_loaded [8][8];
  int  gen_n, gen_m, gen_nf;

  bit  in_taken = 1'b0;
  bit  no_idle = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  rx_hold = 0;
  int  cycles = 0;
  int  errors = 0;
  int  n_req = 0;
  int  n_res = 0;
  int  n_factor = 0;
  int  n_solve = 0;
  int  n_incompat = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint absv(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip32((a * b) / 65536);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    if (b == 0) return (a > 0) ? 64'sd2147483647 : ((a < 0) ? -64'sd2147483648 : 64'sd0);
    return clip32((a * 65536) / b);
  endfunction

  function automatic int eff_size(logic [3:0] v);
    if (v == 0) return 1;
    return (v > 8) ? 8 : int'(v);
  endfunction

  task automatic push_answer(lfp_pkg::kind_e k, logic [2:0] r, logic [2:0] c,
                             longint v, logic [2:0] rs, logic [2:0] cs, logic lst);
    answer_t a;
    a.kind = k; a.rank = shadow_rank; a.row = r; a.col = c;
    a.value = v[31:0]; a.rsrc = rs; a.csrc = cs; a.last = lst;
    answer_q.push_back(a);
  endtask

  // In-place factoring with full pivoting
  task automatic factor_matrix();
    int n, br, bc;
    longint best, lm;
    logic signed [31:0] t;
    logic [2:0] u;
    n = eff_size(size_reg);
    for (int i = 0; i < 8; i++) begin
      row_perm[i] = 3'(i);
      col_perm[i] = 3'(i);
    end
    shadow_rank = 0;
    for (int i = 0; i < n; i++) begin
      br = i; bc = i;
      best = absv(longint'(lu_mat[i][i]));
      for (int j = i; j < n; j++)
        for (int k = i; k < n; k++)
          if (absv(longint'(lu_mat[j][k])) > best) begin
            best = absv(longint'(lu_mat[j][k])); br = j; bc = k;
          end
      u = row_perm[i]; row_perm[i] = row_perm[br]; row_perm[br] = u;
      u = col_perm[i]; col_perm[i] = col_perm[bc]; col_perm[bc] = u;
      for (int k = 0; k < n; k++) begin
        t = lu_mat[i][k]; lu_mat[i][k] = lu_mat[br][k]; lu_mat[br][k] = t;
      end
      for (int j = 0; j < n; j++) begin
        t = lu_mat[j][i]; lu_mat[j][i] = lu_mat[j][bc]; lu_mat[j][bc] = t;
      end
      if (absv(longint'(lu_mat[i][i])) < piv_th) begin
        shadow_rank = 4'(i);
        break;
      end
      shadow_rank = 4'(i + 1);
      for (int j = i + 1; j < n; j++) begin
        lm = qdiv(longint'(lu_mat[j][i]), longint'(lu_mat[i][i]));
        lu_mat[j][i] = lm[31:0];
        for (int k = i + 1; k < n; k++)
          lu_mat[j][k] = 32'(clip32(longint'(lu_mat[j][k]) - qmul(longint'(lu_mat[i][k]), lm)));
      end
    end
  endtask

  // Forward substitution, compatibility check, back substitution
  task automatic solve_system();
    int n, m;
    longint y [8][8];
    longint v;
    n = eff_size(size_reg);
    m = eff_size(cols_reg);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < m; j++) begin
        v = longint'(rhs_mat[row_perm[i]][j]);
        for (int k = 0; k < i; k++) v = clip32(v - qmul(longint'(lu_mat[i][k]), y[k][j]));
        y[i][j] = v;
      end
    for (int i = 0; i < n; i++)
      if (absv(longint'(lu_mat[i][i])) < piv_th)
        for (int j = 0; j < m; j++)
          if (absv(y[i][j]) > res_th) begin
            push_answer(lfp_pkg::KIND_INC, '0, '0, 0, '0, '0, 1'b1);
            n_incompat++;
            return;
          end
    for (int i = n - 1; i >= 0; i--) begin
      if (i >= shadow_rank) continue;
      for (int j = 0; j < m; j++) begin
        v = y[i][j];
        for (int k = i + 1; k < n; k++) v = clip32(v - qmul(longint'(lu_mat[i][k]), y[k][j]));
        y[i][j] = qdiv(v, longint'(lu_mat[i][i]));
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < m; j++)
        push_answer(lfp_pkg::KIND_SOL, col_perm[i], 3'(j), y[i][j], '0, '0,
                    (i + 1 == n && j + 1 == m));
  endtask

  task automatic predict(req_t q);
    case (q.action)
      lfp_pkg::ACT_LOAD_M: lu_mat[q.row][q.col] = q.value;
      lfp_pkg::ACT_LOAD_R: rhs_mat[q.row][q.col] = q.value;
      lfp_pkg::ACT_FACTOR: begin
        factor_matrix();
        push_answer(lfp_pkg::KIND_DONE, '0, '0, 0, '0, '0, 1'b1);
        n_factor++;
      end
      lfp_pkg::ACT_SOLVE: begin
        solve_system();
        n_solve++;
      end
      lfp_pkg::ACT_READ:
        push_answer(lfp_pkg::KIND_ENTRY, q.row, q.col, longint'(lu_mat[q.row][q.col]),
                    row_perm[q.row], col_perm[q.col], 1'b1);
      default: ;
    endcase
  endtask

  // Monitor: count cycles, take requests and check results
  always @(posedge clk_i) begin
    req_t q;
    answer_t a;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, answer_q.size());
      $display("TB_ERROR");
      $finish;
    end
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      q.action = action_i; q.row = row_i; q.col = col_i; q.value = value_i;
      predict(q);
      n_req++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_res++;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind=%0d value=%h", kind_o, value_res_o);
      end else begin
        a = answer_q.pop_front();
        if (kind_o !== a.kind || rank_o !== a.rank || row_res_o !== a.row ||
            col_res_o !== a.col || value_res_o !== a.value || row_source_o !== a.rsrc ||
            col_source_o !== a.csrc || last_o !== a.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp k%0d rk%0d r%0d c%0d v%h rs%0d cs%0d l%0d / got k%0d rk%0d r%0d c%0d v%h rs%0d cs%0d l%0d",
                     a.kind, a.rank, a.row, a.col, a.value, a.rsrc, a.csrc, a.last,
                     kind_o, rank_o, row_res_o, col_res_o, value_res_o, row_source_o,
                     col_source_o, last_o);
        end
      end
    end
  end

  // Driver: hold a request until taken, then advance with random gaps
  always @(negedge clk_i) begin
    req_t q;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0 && !no_idle && $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(0, 4);
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        q = pending_q.pop_front();
        action_i <= q.action; row_i <= q.row; col_i <= q.col; value_i <= q.value;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off on request, else random stall bursts
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send(logic [2:0] a, int r, int c, logic [31:0] v);
    req_t q;
    q.action = a; q.row = 3'(r); q.col = 3'(c); q.value = v;
    if (a == lfp_pkg::ACT_LOAD_M) mat_loaded[r][c] = 1'b1;
    if (a == lfp_pkg::ACT_LOAD_R) rhs_loaded[r][c] = 1'b1;
    pending_q.push_back(q);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      2:       return 32'($signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200);
      default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    endcase
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || answer_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Drain, then write all four registers
  task automatic set_config(logic [3:0] n, logic [3:0] m, logic [16:0] pt, logic [16:0] rt);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= lfp_pkg::CFG_MATRIX_SIZE; cfg_data_i <= 17'(n);
    @(negedge clk_i);
    cfg_index_i <= lfp_pkg::CFG_RHS_COLUMNS; cfg_data_i <= 17'(m);
    @(negedge clk_i);
    cfg_index_i <= lfp_pkg::CFG_PIVOT_TH; cfg_data_i <= pt;
    @(negedge clk_i);
    cfg_index_i <= lfp_pkg::CFG_RESID_TH; cfg_data_i <= rt;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = n; cols_reg = m; piv_th = longint'(pt); res_th = longint'(rt);
    gen_n = eff_size(n);
    gen_m = eff_size(m);
  endtask

  task automatic load_matrix();
    for (int i = 0; i < gen_n; i++)
      for (int k = 0; k < gen_n; k++) send(lfp_pkg::ACT_LOAD_M, i, k, rand_value());
  endtask

  // Fill any entry that a factor or solve would read
  task automatic fill_gaps(bit with_rhs);
    int rows;
    rows = (gen_nf > gen_n) ? gen_nf : gen_n;
    for (int i = 0; i < gen_n; i++)
      for (int k = 0; k < gen_n; k++)
        if (!mat_loaded[i][k]) send(lfp_pkg::ACT_LOAD_M, i, k, rand_value());
    if (with_rhs)
      for (int i = 0; i < rows; i++)
        for (int j = 0; j < gen_m; j++)
          if (!rhs_loaded[i][j]) send(lfp_pkg::ACT_LOAD_R, i, j, rand_value());
  endtask

  task automatic factor_req();
    fill_gaps(1'b0);
    send(lfp_pkg::ACT_FACTOR, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
    gen_nf = gen_n;
  endtask

  task automatic solve_req();
    fill_gaps(1'b1);
    send(lfp_pkg::ACT_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
  endtask

  task automatic read_req();
    int r, c;
    r = 0; c = 0;
    for (int t = 0; t < 20; t++) begin
      r = $urandom_range(0, 7);
      c = $urandom_range(0, 7);
      if (mat_loaded[r][c]) break;
    end
    if (!mat_loaded[r][c]) begin
      r = 0; c = 0;
    end
    send(lfp_pkg::ACT_READ, r, c, $urandom);
  endtask

  // One well-formed pass with some noise mixed in
  task automatic random_pass();
    int rows;
    load_matrix();
    factor_req();
    repeat ($urandom_range(1, 3)) read_req();
    rows = gen_n;
    for (int i = 0; i < rows; i++)
      for (int j = 0; j < gen_m; j++)
        if ($urandom_range(0, 2) != 0) send(lfp_pkg::ACT_LOAD_R, i, j, rand_value());
    solve_req();
    case ($urandom_range(0, 2))
      0: send(3'($urandom_range(5, 7)), $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      1: send(lfp_pkg::ACT_LOAD_M, $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
      default: read_req();
    endcase
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      row_perm[i] = 3'(i);
      col_perm[i] = 3'(i);
      for (int j = 0; j < 8; j++) begin
        lu_mat[i][j] = '0; rhs_mat[i][j] = '0;
      end
    end
    shadow_rank = 0; size_reg = 4'd8; cols_reg = 4'd1; piv_th = 1; res_th = 1;
    gen_n = 8; gen_m = 1; gen_nf = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: saturating entries, reads, unknown actions
    set_config(4'd2, 4'd1, 17'd1, 17'd1);
    send(lfp_pkg::ACT_LOAD_M, 0, 0, 32'h7fff_ffff);
    send(lfp_pkg::ACT_LOAD_M, 0, 1, 32'h8000_0000);
    send(lfp_pkg::ACT_LOAD_M, 1, 0, 32'h0001_0000);
    send(lfp_pkg::ACT_LOAD_M, 1, 1, 32'hffff_0000);
    send(lfp_pkg::ACT_FACTOR, 0, 0, 0);
    send(lfp_pkg::ACT_READ, 0, 0, 0);
    send(lfp_pkg::ACT_READ, 1, 1, 0);
    send(lfp_pkg::ACT_LOAD_R, 0, 0, 32'h0002_0000);
    send(lfp_pkg::ACT_LOAD_R, 1, 0, 32'h7fff_ffff);
    send(lfp_pkg::ACT_SOLVE, 0, 0, 0);
    send(3'd5, 7, 7, 32'hffff_ffff);
    send(3'd6, 0, 0, 0);
    send(3'd7, 5, 2, 32'h1234_5678);
    // Rank-deficient matrix with an incompatible right-hand side
    send(lfp_pkg::ACT_LOAD_M, 0, 0, 32'h0001_0000);
    send(lfp_pkg::ACT_LOAD_M, 0, 1, 32'h0001_0000);
    send(lfp_pkg::ACT_LOAD_M, 1, 0, 32'h0000_0000);
    send(lfp_pkg::ACT_LOAD_M, 1, 1, 32'h0000_0000);
    send(lfp_pkg::ACT_FACTOR, 0, 0, 0);
    send(lfp_pkg::ACT_LOAD_R, 1, 0, 32'h0005_0000);
    send(lfp_pkg::ACT_SOLVE, 0, 0, 0);
    gen_nf = 2;
    // Zero threshold with a zero matrix: pivots divide by zero
    set_config(4'd2, 4'd1, 17'd0, 17'd0);
    for (int i = 0; i < 2; i++)
      for (int k = 0; k < 2; k++) send(lfp_pkg::ACT_LOAD_M, i, k, 32'h0);
    send(lfp_pkg::ACT_FACTOR, 0, 0, 0);
    send(lfp_pkg::ACT_SOLVE, 0, 0, 0);

    // Random passes over several settings
    set_config(4'd3, 4'd2, 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
    random_pass();
    set_config(4'd0, 4'd15, 17'd0, 17'd0);
    random_pass();
    // Full size with an oversized pivot threshold
    set_config(4'd9, 4'd1, 17'h1ffff, 17'($urandom_range(0, 65536)));
    load_matrix();
    factor_req();
    // Hold the result side while requests keep coming
    wait (pending_q.size() == 0);
    rx_hold = 4000;
    no_idle = 1'b1;
    solve_req();
    repeat (4) read_req();

    wait_idle();
    $display("covered %0d requests and %0d results: %0d factor runs, %0d solves (%0d incompatible)",
             n_req, n_res, n_factor, n_solve, n_incompat);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, answer_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: lu_full_pivot_solver.f
rtl/lfp_pkg.sv
rtl/lfp_div.sv
rtl/lfp_dp.sv
rtl/lfp_ctrl.sv
rtl/lu_full_pivot_solver.sv
verif/tb_top.sv
